// File: sv/ngga_pkg.sv
// shared types, constants and helper functions for the gga field extractor
// no dependencies; imported by every module of the block
package ngga_pkg;

  localparam int MAX_CHARS  = 82;
  localparam int SCAN_LIMIT = 69;
  localparam int SCAN_END   = (SCAN_LIMIT < MAX_CHARS) ? SCAN_LIMIT : MAX_CHARS;
  localparam int POS_W      = $clog2(MAX_CHARS + 1);
  localparam int HDR_LEN    = 5;
  localparam int FRAC_DIGITS = 4;
  localparam int COMMA_MAX  = 15;

  localparam int FIELD_LAT = 2;
  localparam int FIELD_LON = 4;
  localparam int FIELD_FIX = 6;
  localparam int FIELD_ALT = 9;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;

  typedef enum logic [1:0] {
    ST_HDR_BAD   = 2'd0,
    ST_NO_FIX    = 2'd1,
    ST_GPS_FIX   = 2'd2,
    ST_OTHER_FIX = 2'd3
  } status_t;

  // result kept as bcd digits until the output side
  typedef struct packed {
    status_t     status;
    logic [3:0]  fix_quality;
    logic [11:0] lat_deg;
    logic [23:0] lat_min;
    logic [11:0] lon_deg;
    logic [23:0] lon_min;
    logic [19:0] alt;
  } result_bcd_t;

  // six bcd digits to binary, most significant digit first
  function automatic logic [19:0] bcd_to_bin(input logic [23:0] bcd);
    logic [19:0] acc;
    acc = '0;
    for (int i = 5; i >= 0; i--) begin
      acc = 20'(acc * 20'd10) + 20'(bcd[4*i +: 4]);
    end
    return acc;
  endfunction

endpackage

// File: sv/ngga_scanner.sv
// per-sentence scan state, header check, field decoding and held values
// depends on ngga_pkg
module ngga_scanner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           char_byte,
  input  logic                 last_byte,
  output ngga_pkg::result_bcd_t res_next
);
  import ngga_pkg::*;

  typedef struct packed {
    logic [19:0] int_bcd;
    logic [15:0] frac_bcd;
    logic [2:0]  frac_cnt;
    logic        point_seen;
  } number_t;

  typedef struct packed {
    logic [11:0] deg;
    logic [23:0] min;
  } pos_bcd_t;

  function automatic pos_bcd_t to_pos(input number_t n);
    pos_bcd_t p;
    p.deg = n.int_bcd[19:8];
    p.min = {n.int_bcd[7:0], n.frac_bcd};
    return p;
  endfunction

  function automatic logic [19:0] to_alt(input number_t n);
    return {n.int_bcd[15:0], n.frac_bcd[15:12]};
  endfunction

  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd1:    ch = CH_G;
      3'd2:    ch = CH_P;
      3'd3:    ch = CH_G;
      3'd4:    ch = CH_G;
      default: ch = CH_A;
    endcase
    return ch;
  endfunction

  logic [POS_W-1:0] char_position, char_position_next;
  logic             header_ok, header_ok_next;
  logic [3:0]       comma_count, comma_count_next;
  number_t          number, number_next;
  logic [3:0]       fix_digit, fix_digit_next;
  logic             field_start, field_start_next;
  pos_bcd_t         pending_lat, pending_lat_next;
  pos_bcd_t         pending_lon, pending_lon_next;
  pos_bcd_t         held_lat, held_lat_next;
  pos_bcd_t         held_lon, held_lon_next;
  logic [19:0]      held_alt, held_alt_next;

  logic             is_digit;
  logic [3:0]       digit;
  status_t          status;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign digit    = char_byte[3:0];

  always_comb begin
    header_ok_next   = header_ok;
    comma_count_next = comma_count;
    number_next      = number;
    fix_digit_next   = fix_digit;
    field_start_next = field_start;
    pending_lat_next = pending_lat;
    pending_lon_next = pending_lon;
    held_lat_next    = held_lat;
    held_lon_next    = held_lon;
    held_alt_next    = held_alt;
    status           = ST_NO_FIX;

    if (char_position == '0) begin
      header_ok_next   = 1'b1;
      comma_count_next = '0;
      number_next      = '0;
      fix_digit_next   = '0;
      pending_lat_next = '0;
      pending_lon_next = '0;
      field_start_next = 1'b0;
    end else if (char_position < POS_W'(SCAN_END)) begin
      if (char_position <= POS_W'(HDR_LEN) && char_byte != header_char(char_position[2:0])) begin
        header_ok_next = 1'b0;
      end
      if (char_byte == CH_COMMA) begin
        // close the field that the comma ends
        if (comma_count == 4'(FIELD_LAT)) begin
          pending_lat_next = to_pos(number_next);
        end else if (comma_count == 4'(FIELD_LON)) begin
          pending_lon_next = to_pos(number_next);
        end else if (comma_count == 4'(FIELD_ALT)) begin
          if (header_ok_next && fix_digit_next != '0) held_alt_next = to_alt(number_next);
        end
        number_next = '0;
        if (comma_count < 4'(COMMA_MAX)) comma_count_next = comma_count + 4'd1;
        field_start_next = 1'b1;
      end else begin
        if (comma_count == 4'(FIELD_FIX) && field_start) begin
          fix_digit_next = is_digit ? digit : 4'd0;
        end
        field_start_next = 1'b0;
        if (char_byte == CH_POINT) begin
          number_next.point_seen = 1'b1;
        end else if (is_digit) begin
          if (!number.point_seen) begin
            // keeping the last five digits is the modulo 100000
            number_next.int_bcd = {number.int_bcd[15:0], digit};
          end else if (number.frac_cnt < 3'(FRAC_DIGITS)) begin
            unique case (number.frac_cnt[1:0])
              2'd0: number_next.frac_bcd[15:12] = digit;
              2'd1: number_next.frac_bcd[11:8]  = digit;
              2'd2: number_next.frac_bcd[7:4]   = digit;
              2'd3: number_next.frac_bcd[3:0]   = digit;
            endcase
            number_next.frac_cnt = number.frac_cnt + 3'd1;
          end
        end
      end
    end

    if (last_byte) begin
      // end of sentence closes the open field
      if (comma_count_next == 4'(FIELD_LAT)) begin
        pending_lat_next = to_pos(number_next);
      end else if (comma_count_next == 4'(FIELD_LON)) begin
        pending_lon_next = to_pos(number_next);
      end else if (comma_count_next == 4'(FIELD_ALT)) begin
        if (header_ok_next && fix_digit_next != '0) held_alt_next = to_alt(number_next);
      end
      number_next = '0;
      priority if (!header_ok_next)       status = ST_HDR_BAD;
      else if (fix_digit_next == 4'd0)    status = ST_NO_FIX;
      else if (fix_digit_next == 4'd1)    status = ST_GPS_FIX;
      else                                status = ST_OTHER_FIX;
      if (status == ST_GPS_FIX || status == ST_OTHER_FIX) begin
        held_lat_next = pending_lat_next;
        held_lon_next = pending_lon_next;
      end
      char_position_next = '0;
    end else begin
      char_position_next = (char_position < POS_W'(MAX_CHARS)) ?
                           char_position + POS_W'(1) : POS_W'(MAX_CHARS);
    end
  end

  always_comb begin
    res_next.status      = status;
    res_next.fix_quality = header_ok_next ? fix_digit_next : 4'd0;
    res_next.lat_deg     = held_lat_next.deg;
    res_next.lat_min     = held_lat_next.min;
    res_next.lon_deg     = held_lon_next.deg;
    res_next.lon_min     = held_lon_next.min;
    res_next.alt         = held_alt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      header_ok     <= 1'b1;
      comma_count   <= '0;
      number        <= '0;
      fix_digit     <= '0;
      field_start   <= 1'b0;
      pending_lat   <= '0;
      pending_lon   <= '0;
      held_lat      <= '0;
      held_lon      <= '0;
      held_alt      <= '0;
    end else if (fire) begin
      char_position <= char_position_next;
      header_ok     <= header_ok_next;
      comma_count   <= comma_count_next;
      number        <= number_next;
      fix_digit     <= fix_digit_next;
      field_start   <= field_start_next;
      pending_lat   <= pending_lat_next;
      pending_lon   <= pending_lon_next;
      held_lat      <= held_lat_next;
      held_lon      <= held_lon_next;
      held_alt      <= held_alt_next;
    end
  end

endmodule

// File: sv/ngga_result.sv
// result register with valid/stall handshake and bcd to binary conversion
// depends on ngga_pkg
module ngga_result (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ngga_pkg::result_bcd_t res_next,
  input  logic                  result_stall,
  output logic                  result_valid,
  output logic [1:0]            status,
  output logic [3:0]            fix_quality,
  output logic [9:0]            lat_degrees,
  output logic [19:0]           lat_minutes_e4,
  output logic [9:0]            lon_degrees,
  output logic [19:0]           lon_minutes_e4,
  output logic [16:0]           altitude_dm
);
  import ngga_pkg::*;

  result_bcd_t res;
  logic [19:0] lat_deg_bin, lon_deg_bin, alt_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

  assign lat_deg_bin    = bcd_to_bin({12'd0, res.lat_deg});
  assign lon_deg_bin    = bcd_to_bin({12'd0, res.lon_deg});
  assign alt_bin        = bcd_to_bin({4'd0, res.alt});

  assign status         = res.status;
  assign fix_quality    = res.fix_quality;
  assign lat_degrees    = lat_deg_bin[9:0];
  assign lat_minutes_e4 = bcd_to_bin(res.lat_min);
  assign lon_degrees    = lon_deg_bin[9:0];
  assign lon_minutes_e4 = bcd_to_bin(res.lon_min);
  assign altitude_dm    = alt_bin[16:0];

endmodule

// File: sv/nmea_gga_field_extractor_top.sv
// top level: byte input register, scanner and result register
// a last byte passes the input register, then loads the result register
// throughput: one byte request per cycle while byte_stall is low
// only a last byte is held back, while a finished result waits on result_stall
// reset (rst, synchronous, active high) clears scan state, held position and altitude
// depends on ngga_pkg, ngga_scanner, ngga_result
module nmea_gga_field_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  char_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [3:0]  fix_quality,
  output logic [9:0]  lat_degrees,
  output logic [19:0] lat_minutes_e4,
  output logic [9:0]  lon_degrees,
  output logic [19:0] lon_minutes_e4,
  output logic [16:0] altitude_dm
);
  import ngga_pkg::*;

  // input register
  logic        in_valid;
  logic [7:0]  in_char;
  logic        in_last;
  logic        byte_accept;
  // byte leaves the input register and updates the scan state
  logic        proc_fire;
  result_bcd_t res_next;

  // a last byte needs a free result slot; other bytes always proceed
  assign proc_fire   = in_valid && !(in_last && result_valid && result_stall);
  assign byte_stall  = in_valid && !proc_fire;
  assign byte_accept = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_accept) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      in_char <= char_byte;
      in_last <= last_byte;
    end
  end

  ngga_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .fire      (proc_fire),
    .char_byte (in_char),
    .last_byte (in_last),
    .res_next  (res_next)
  );

  // result register, loaded by the byte that closes the sentence
  ngga_result u_result (
    .clk            (clk),
    .rst            (rst),
    .load           (proc_fire && in_last),
    .res_next       (res_next),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .status         (status),
    .fix_quality    (fix_quality),
    .lat_degrees    (lat_degrees),
    .lat_minutes_e4 (lat_minutes_e4),
    .lon_degrees    (lon_degrees),
    .lon_minutes_e4 (lon_minutes_e4),
    .altitude_dm    (altitude_dm)
  );

endmodule
